// ===== sv/scbh_pkg.sv =====
// ---------------------------------------------------------------------------
// scbh_pkg: shared types and constants of the strided cell bin histogram
// Item and result structs, register indexes, command codes, queue depths.
// ---------------------------------------------------------------------------
package scbh_pkg;

	// default geometry
	localparam int CELLS_DEFAULT     = 4096;
	localparam int BIN_COUNT_DEFAULT = 10;

	// field widths fixed by the interface
	localparam int CMD_W       = 1;
	localparam int WEIGHT_W    = 8;
	localparam int CELL_IDX_W  = 12;
	localparam int BIN_IDX_W   = 4;
	localparam int COUNT_W     = 16;
	localparam int MASK_W      = 16;
	localparam int MASK_BIT_W  = 4;
	localparam int ENTRY_W     = COUNT_W + MASK_W;

	// configuration registers
	localparam int STRIDE_W    = 12;
	localparam int CELLS_USE_W = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0]   REG_STRIDE       = 1'b0;
	localparam logic [CFG_IDX_W-1:0]   REG_CELLS_IN_USE = 1'b1;
	localparam logic [STRIDE_W-1:0]    STRIDE_RESET     = 12'd37;
	localparam logic [CELLS_USE_W-1:0] CELLS_USE_RESET  = 13'd4096;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// queue depths (powers of two)
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic [CMD_W-1:0]           cmd;
		logic signed [WEIGHT_W-1:0] weight;
		logic [CELL_IDX_W-1:0]      cell_index;
		logic [BIN_IDX_W-1:0]       bin_index;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bin_count;
		logic [MASK_W-1:0]  value_mask;
	} result_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic                  is_read;
		logic                  in_range;
		logic [MASK_BIT_W-1:0] mask_bit;
	} op_ctl_t;

	// modulus reduction sequencer
	typedef enum logic [1:0] {
		RED_IDLE,
		RED_LOAD,
		RED_RUN
	} red_state_t;

endpackage

// ===== sv/scbh_fifo.sv =====
// ---------------------------------------------------------------------------
// scbh_fifo: small register queue
// First-word-fall-through queue with occupancy output; DEPTH is a power of two.
// ---------------------------------------------------------------------------
module scbh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	output logic                         full,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = store_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/scbh_front.sv =====
// ---------------------------------------------------------------------------
// scbh_front: configuration, cell cursor and item classification
// Holds the registers and the cursor, reduces cursor and stride modulo the
// active cell count after each register write, and turns each item into an
// entry address plus a small control word for the back end.
// ---------------------------------------------------------------------------
module scbh_front
	import scbh_pkg::*;
#(
	parameter int CELLS     = CELLS_DEFAULT,
	parameter int BIN_COUNT = BIN_COUNT_DEFAULT,
	parameter int ADDR_W    = $clog2(CELLS_DEFAULT * BIN_COUNT_DEFAULT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [CFG_IDX_W-1:0]                cfg_idx,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	input  logic                                take,
	input  item_t                               item,
	output logic                                q_push,
	output logic [$bits(op_ctl_t)+ADDR_W-1:0]   q_data,
	output logic                                reducing
);

	localparam int CELL_W = $clog2(CELLS);
	localparam int M_W    = $clog2(CELLS + 1);
	localparam int R_W    = M_W + 1;
	localparam int DIV_W  = (CELL_W > STRIDE_W) ? CELL_W : STRIDE_W;
	localparam int STEP_W = $clog2(DIV_W);

	logic [STRIDE_W-1:0]    stride_q;
	logic [CELLS_USE_W-1:0] cells_q;
	logic [CELL_W-1:0]      cursor_q;
	logic [CELL_W-1:0]      cell_q;
	logic [CELL_W-1:0]      stride_mod_q;

	red_state_t             red_q;
	red_state_t             red_nxt;
	logic                   red_load;
	logic                   red_step;
	logic                   red_done;
	logic [STEP_W-1:0]      step_q;
	logic [DIV_W-1:0]       div_c_q;
	logic [DIV_W-1:0]       div_s_q;
	logic [M_W-1:0]         rem_c_q;
	logic [M_W-1:0]         rem_s_q;
	logic [R_W-1:0]         rc_sh;
	logic [R_W-1:0]         rs_sh;
	logic [R_W-1:0]         rc_nx;
	logic [R_W-1:0]         rs_nx;

	logic [M_W-1:0]         mod_c;
	logic [R_W-1:0]         sum_c;
	logic [R_W-1:0]         sum_wrap;
	logic [CELL_W-1:0]      cell_nxt;

	logic [WEIGHT_W-1:0]    biased;
	logic [15:0]            bin_prod;
	logic [BIN_IDX_W-1:0]   bin_add;
	logic                   rd_in_range;
	logic [ADDR_W-1:0]      addr_add;
	logic [ADDR_W-1:0]      addr_rd;
	op_ctl_t                ctl;

	// active modulus: zero or oversized count falls back to all cells
	always_comb begin
		if (cells_q == '0 || 32'(cells_q) > CELLS) begin
			mod_c = M_W'(CELLS);
		end else begin
			mod_c = M_W'(cells_q);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			cells_q  <= CELLS_USE_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_STRIDE: begin
					stride_q <= cfg_data[STRIDE_W-1:0];
				end
				REG_CELLS_IN_USE: begin
					cells_q <= cfg_data[CELLS_USE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// reduction sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= RED_LOAD;
		end else begin
			red_q <= red_nxt;
		end
	end

	always_comb begin
		red_nxt  = red_q;
		red_load = 1'b0;
		red_step = 1'b0;
		red_done = 1'b0;
		case (red_q)
			RED_IDLE: begin
			end
			RED_LOAD: begin
				red_load = 1'b1;
				red_nxt  = RED_RUN;
			end
			RED_RUN: begin
				red_step = 1'b1;
				if (step_q == STEP_W'(DIV_W - 1)) begin
					red_done = 1'b1;
					red_nxt  = RED_IDLE;
				end
			end
			default: begin
				red_nxt = RED_IDLE;
			end
		endcase
		// any register write restarts the reduction
		if (cfg_wen) begin
			red_nxt = RED_LOAD;
		end
	end

	assign reducing = (red_q != RED_IDLE);

	// restoring remainder step, one dividend bit per cycle, cursor and stride
	assign rc_sh = {rem_c_q, div_c_q[DIV_W-1]};
	assign rs_sh = {rem_s_q, div_s_q[DIV_W-1]};
	assign rc_nx = (rc_sh >= R_W'(mod_c)) ? rc_sh - R_W'(mod_c) : rc_sh;
	assign rs_nx = (rs_sh >= R_W'(mod_c)) ? rs_sh - R_W'(mod_c) : rs_sh;

	always_ff @(posedge clk) begin
		if (red_load) begin
			step_q  <= '0;
			div_c_q <= DIV_W'(cursor_q);
			div_s_q <= DIV_W'(stride_q);
			rem_c_q <= '0;
			rem_s_q <= '0;
		end else if (red_step) begin
			step_q  <= step_q + 1'b1;
			div_c_q <= div_c_q << 1;
			div_s_q <= div_s_q << 1;
			rem_c_q <= rc_nx[M_W-1:0];
			rem_s_q <= rs_nx[M_W-1:0];
		end
	end

	// cursor advance: both terms already below the modulus
	assign sum_c    = R_W'(cell_q) + R_W'(stride_mod_q);
	assign sum_wrap = (sum_c >= R_W'(mod_c)) ? sum_c - R_W'(mod_c) : sum_c;
	assign cell_nxt = sum_wrap[CELL_W-1:0];

	// cursor keeps the raw position, cell holds it reduced by the modulus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			cell_q       <= '0;
			stride_mod_q <= '0;
		end else if (red_done) begin
			cell_q       <= rc_nx[CELL_W-1:0];
			stride_mod_q <= rs_nx[CELL_W-1:0];
		end else if (take && item.cmd == CMD_ADD) begin
			cursor_q <= cell_nxt;
			cell_q   <= cell_nxt;
		end
	end

	// classification: bin of a weight, entry addresses, read range check
	assign biased      = {~item.weight[WEIGHT_W-1], item.weight[WEIGHT_W-2:0]};
	assign bin_prod    = 16'(biased) * 16'(BIN_COUNT);
	assign bin_add     = bin_prod[11:8];
	assign addr_add    = ADDR_W'(32'(cell_q) * 32'(BIN_COUNT) + 32'(bin_add));
	assign addr_rd     = ADDR_W'(32'(item.cell_index) * 32'(BIN_COUNT)
	                     + 32'(item.bin_index));
	assign rd_in_range = (32'(item.cell_index) < CELLS) && (32'(item.bin_index) < BIN_COUNT);

	always_comb begin
		ctl.is_read  = (item.cmd == CMD_READ);
		ctl.in_range = ctl.is_read ? rd_in_range : 1'b1;
		ctl.mask_bit = biased[MASK_BIT_W-1:0];
	end

	assign q_push = take;
	assign q_data = {ctl, (ctl.is_read ? addr_rd : addr_add)};

endmodule

// ===== sv/scbh_back.sv =====
// ---------------------------------------------------------------------------
// scbh_back: entry memory with read-modify-write pipeline
// Clears the memory after reset, then issues one queued operation per cycle:
// a forwarded count/mask update, or a read whose result goes to a free slot.
// ---------------------------------------------------------------------------
module scbh_back
	import scbh_pkg::*;
#(
	parameter int CELLS     = CELLS_DEFAULT,
	parameter int BIN_COUNT = BIN_COUNT_DEFAULT,
	parameter int ADDR_W    = $clog2(CELLS_DEFAULT * BIN_COUNT_DEFAULT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  logic [$bits(op_ctl_t)+ADDR_W-1:0]   q_data,
	output logic                                q_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_level,
	output logic                                out_push,
	output result_t                             out_data,
	output logic                                clearing
);

	localparam int DEPTH = CELLS * BIN_COUNT;

	logic [ENTRY_W-1:0] entry_mem [DEPTH];

	op_ctl_t            head_ctl;
	logic [ADDR_W-1:0]  head_addr;
	logic               room;
	logic               issue;

	logic               clr_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	logic               v_s1;
	op_ctl_t            ctl_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               fwd_v_s1;
	logic [ENTRY_W-1:0] fwd_s1;
	logic [ENTRY_W-1:0] rd_data_q;
	logic [ENTRY_W-1:0] data_s1;
	logic [COUNT_W-1:0] cnt_old;
	logic [COUNT_W-1:0] cnt_new;
	logic [MASK_W-1:0]  mask_new;
	logic [ENTRY_W-1:0] entry_new;
	logic               wr_s1;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	assign {head_ctl, head_addr} = q_data;

	// a read issues only with a result slot guaranteed
	assign room  = (32'(out_level) + 32'(v_s1 && ctl_s1.is_read)) < OUT_DEPTH;
	assign issue = !clr_q && !q_empty && (!head_ctl.is_read || room);
	assign q_pop = issue;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign clearing = clr_q;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	// update of the entry in stage 1
	assign data_s1   = fwd_v_s1 ? fwd_s1 : rd_data_q;
	assign cnt_old   = data_s1[ENTRY_W-1:MASK_W];
	assign cnt_new   = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
	assign mask_new  = data_s1[MASK_W-1:0] | (MASK_W'(1) << ctl_s1.mask_bit);
	assign entry_new = {cnt_new, mask_new};
	assign wr_s1     = v_s1 && !ctl_s1.is_read;

	// stage 1 payload; forward a write that lands as the memory is read
	always_ff @(posedge clk) begin
		if (issue) begin
			ctl_s1   <= head_ctl;
			addr_s1  <= head_addr;
			fwd_v_s1 <= wr_s1 && (addr_s1 == head_addr);
			fwd_s1   <= entry_new;
		end
	end

	// memory write port: clear pass or update
	always_comb begin
		mem_we    = clr_q | wr_s1;
		mem_waddr = clr_q ? clr_addr_q : addr_s1;
		mem_wdata = clr_q ? '0 : entry_new;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= entry_mem[head_addr];
	end

	// read result
	assign out_push = v_s1 && ctl_s1.is_read;
	assign out_data = ctl_s1.in_range ? result_t'(data_s1) : '0;

endmodule

// ===== sv/strided_cell_bin_histogram_core.sv =====
// ---------------------------------------------------------------------------
// strided_cell_bin_histogram_core: per-cell weight histogram with strided cursor
// Add items bin a signed weight into the cell under the cursor; read items
// return the count and presence mask of one cell and bin.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter on push/full/cmd_item, taken when push is high and full low.
//   Results leave on empty/pop/result; the head is taken when pop is high and
//   empty low. Only read items produce a result.
//   Registers are written through cfg_wen/cfg_idx/cfg_data, only while idle.
//   Throughput: one item per cycle while full is low, set by the single
//   read-modify-write port of the entry memory (update forwarding keeps
//   back-to-back adds to the same entry at full rate).
//   A read goes through the operation queue and stage 1 to the result queue.
//   Reset: the entry memory is swept clear, one entry per cycle, over all
//   CELLS*BIN_COUNT entries (40960 by default) with full held high.
//   After every register write full stays high through one load and
//   max(12, log2 CELLS) remainder steps while cursor and stride are reduced.
//   When pop stays low the 4-entry result queue fills, reads wait in the
//   4-entry operation queue, and full rises once that queue is full too.
// ---------------------------------------------------------------------------
module strided_cell_bin_histogram_core
	import scbh_pkg::*;
#(
	parameter int CELLS     = CELLS_DEFAULT,
	parameter int BIN_COUNT = BIN_COUNT_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  item_t                  cmd_item,
	output logic                   full,
	input  logic                   pop,
	output result_t                result,
	output logic                   empty,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W = $clog2(CELLS * BIN_COUNT);
	localparam int OP_W   = $bits(op_ctl_t) + ADDR_W;
	localparam int OLVL_W = $clog2(OUT_DEPTH + 1);

	logic              take;
	logic              reducing;
	logic              clearing;
	logic              mid_push;
	logic [OP_W-1:0]   mid_wdata;
	logic              mid_full;
	logic              mid_pop;
	logic [OP_W-1:0]   mid_rdata;
	logic              mid_empty;
	logic              out_push;
	result_t           out_data;
	logic              out_full;
	logic [OLVL_W-1:0] out_level;
	logic [$bits(result_t)-1:0] out_rdata;

	// input handshake
	assign full = mid_full | clearing | reducing;
	assign take = push & ~full;

	scbh_front #(
		.CELLS     (CELLS),
		.BIN_COUNT (BIN_COUNT),
		.ADDR_W    (ADDR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.take     (take),
		.item     (cmd_item),
		.q_push   (mid_push),
		.q_data   (mid_wdata),
		.reducing (reducing)
	);

	// operation queue between front and back
	scbh_fifo #(
		.WIDTH (OP_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.level  ()
	);

	scbh_back #(
		.CELLS     (CELLS),
		.BIN_COUNT (BIN_COUNT),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (mid_empty),
		.q_data    (mid_rdata),
		.q_pop     (mid_pop),
		.out_level (out_level),
		.out_push  (out_push),
		.out_data  (out_data),
		.clearing  (clearing)
	);

	// result queue
	scbh_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_data),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty),
		.level  (out_level)
	);

	assign result = result_t'(out_rdata);

`ifndef SYNTHESIS
	// read issue credit keeps the result queue from overflowing
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue pushed while full");

	// the clear pass runs once per reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing |=> !clearing)
		else $error("clear pass restarted");

	// nothing is queued or delivered while the memory is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (mid_empty && empty))
		else $error("item in flight during clear pass");
`endif

endmodule

// ===== test/tb_strided_cell_bin_histogram_core.sv =====
// ---------------------------------------------------------------------------
// tb_strided_cell_bin_histogram_core: self-checking bench for the histogram core
// Streams add and read items through the queue ports, keeps its own copy of
// the count and mask stores and of the strided cursor, and compares every
// read result field by field. Covers boundary weights, register extremes,
// same-entry bursts, out-of-range reads and randomized traffic with random
// gaps on both sides.
// ---------------------------------------------------------------------------
module tb_strided_cell_bin_histogram_core;
	import scbh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS       = CELLS_DEFAULT;
	localparam int BINS        = BIN_COUNT_DEFAULT;
	localparam int ENTRIES     = CELLS * BINS;
	localparam int WATCH_LIMIT = 200000;
	localparam int RECENT_MAX  = 64;

	typedef struct packed {
		int cell_id;
		int bin_id;
	} entry_ref_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  push     = 1'b0;
	item_t                 cmd_item = '0;
	logic                  full;
	logic                  pop      = 1'b0;
	result_t               result;
	logic                  empty;
	logic                  cfg_wen  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = REG_STRIDE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// histogram state as the bench sees it
	logic [COUNT_W-1:0] count_mem [ENTRIES];
	logic [MASK_W-1:0]  mask_mem  [ENTRIES];
	int unsigned        cursor_cell;
	int unsigned        step_reg;
	int unsigned        cells_reg;
	result_t            read_expect [$];
	entry_ref_t         recent_entries [$];

	// traffic shaping
	bit feed_gap_en;
	bit drain_stall_en;
	int drain_wait;

	// bookkeeping
	int adds_sent;
	int reads_sent;
	int results_seen;
	int reg_writes;
	int mismatches;
	int stall_cycles;

	strided_cell_bin_histogram_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cmd_item (cmd_item),
		.full     (full),
		.pop      (pop),
		.result   (result),
		.empty    (empty),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------------
	function automatic int unsigned live_modulus();
		if (cells_reg == 0 || cells_reg > CELLS)
			return CELLS;
		return cells_reg;
	endfunction

	// stores cleared, registers at their reset values
	task automatic init_model();
		for (int i = 0; i < ENTRIES; i++) begin
			count_mem[i] = '0;
			mask_mem[i]  = '0;
		end
		cursor_cell = 0;
		step_reg    = 32'(STRIDE_RESET);
		cells_reg   = 32'(CELLS_USE_RESET);
	endtask

	// apply one accepted item; reads queue their expected result
	function automatic void histogram_update(item_t it);
		int unsigned     m, cell_id, bin, slot;
		logic [7:0]      biased;
		result_t         r;
		entry_ref_t      e;
		if (it.cmd == CMD_ADD) begin
			biased  = it.weight ^ 8'h80;
			bin     = (32'(biased) * BINS) >> 8;
			m       = live_modulus();
			cell_id = cursor_cell % m;
			slot    = cell_id * BINS + bin;
			if (count_mem[slot] != COUNT_MAX)
				count_mem[slot] = count_mem[slot] + 1'b1;
			mask_mem[slot] = mask_mem[slot] | (16'h0001 << biased[3:0]);
			cursor_cell    = (cell_id + step_reg) % m;
			e.cell_id = int'(cell_id);
			e.bin_id  = int'(bin);
			recent_entries.push_back(e);
			if (recent_entries.size() > RECENT_MAX)
				void'(recent_entries.pop_front());
			adds_sent++;
		end else begin
			r = '0;
			if (it.cell_index < CELLS && it.bin_index < BINS) begin
				slot         = it.cell_index * BINS + it.bin_index;
				r.bin_count  = count_mem[slot];
				r.value_mask = mask_mem[slot];
			end
			read_expect.push_back(r);
			reads_sent++;
		end
	endfunction

	// ---------------------------------------------------------------------
	// item builders and drivers
	// ---------------------------------------------------------------------
	function automatic item_t add_of(int w);
		item_t it;
		it.cmd        = CMD_ADD;
		it.weight     = WEIGHT_W'(w);
		it.cell_index = CELL_IDX_W'($urandom_range(0, 4095));
		it.bin_index  = BIN_IDX_W'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic item_t read_of(int cell_id, int bin);
		item_t it;
		it.cmd        = CMD_READ;
		it.weight     = WEIGHT_W'($urandom_range(0, 255));
		it.cell_index = CELL_IDX_W'(cell_id);
		it.bin_index  = BIN_IDX_W'(bin);
		return it;
	endfunction

	// present one item, hold it until taken, then predict
	task automatic send_item(item_t it);
		int gap;
		gap = feed_gap_en ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_item <= it;
		push     <= 1'b1;
		do @(posedge clk); while (full);
		histogram_update(it);
	endtask

	// read back one of the recently updated entries
	task automatic read_recent();
		entry_ref_t e;
		if (recent_entries.size() == 0) begin
			send_item(read_of(int'($urandom_range(0, 4095)), 0));
		end else begin
			e = recent_entries[$urandom_range(0, recent_entries.size() - 1)];
			send_item(read_of(e.cell_id, e.bin_id));
		end
	endtask

	// random mix of adds and reads of recent entries
	task automatic run_mix(int n, int read_pct);
		for (int i = 0; i < n; i++) begin
			if (int'($urandom_range(0, 99)) < read_pct)
				read_recent();
			else
				send_item(add_of(int'($urandom_range(0, 255))));
		end
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		push <= 1'b0;
		while (read_expect.size() != 0) @(posedge clk);
		// adds still in flight leave no result; let them retire
		repeat (20) @(posedge clk);
		while (full) @(posedge clk);
		cfg_wen  <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_STRIDE)
			step_reg = 32'(data[STRIDE_W-1:0]);
		else
			cells_reg = 32'(data);
		reg_writes++;
	endtask

	// ---------------------------------------------------------------------
	// result side: random pop stalls and field checks
	// ---------------------------------------------------------------------
	function automatic void check_read_result(result_t got);
		result_t want;
		results_seen++;
		if (read_expect.size() == 0) begin
			$error("unexpected result: bin_count %0d value_mask %04h",
				got.bin_count, got.value_mask);
			mismatches++;
			return;
		end
		want = read_expect.pop_front();
		if (got.bin_count !== want.bin_count) begin
			$error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
			mismatches++;
		end
		if (got.value_mask !== want.value_mask) begin
			$error("value_mask: expected %04h, got %04h", want.value_mask, got.value_mask);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				check_read_result(result);
				drain_wait = drain_stall_en ? $urandom_range(0, 4) : 0;
				pop <= (drain_wait == 0);
			end else if (!pop) begin
				if (drain_wait > 0)
					drain_wait--;
				if (drain_wait == 0)
					pop <= 1'b1;
			end
		end
	end

	// watchdog: cycles in a row with no item or result taken
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCH_LIMIT) begin
			$display("timeout after %0d cycles without progress", stall_cycles);
			$display("tb_strided_cell_bin_histogram_core: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// reset registers: bin edges, weight extremes, back-to-back add/read
	task automatic test_reset_geometry();
		feed_gap_en    = 1'b0;
		drain_stall_en = 1'b0;
		send_item(add_of(-128));
		send_item(read_of(0, 0));
		send_item(add_of(127));
		read_recent();
	endtask

	// every weight once, across all bin boundaries
	task automatic test_bin_edges();
		feed_gap_en    = 1'b1;
		drain_stall_en = 1'b0;
		for (int w = -128; w < 128; w++) begin
			send_item(add_of(w));
			if ((w & 7) == 7)
				read_recent();
		end
	endtask

	// zero stride: back-to-back adds land on one entry
	task automatic test_same_entry();
		write_reg(REG_STRIDE, CFG_DATA_W'(0));
		feed_gap_en    = 1'b0;
		drain_stall_en = 1'b0;
		for (int i = 0; i < 40; i++) begin
			send_item(add_of(((i % 2) == 0) ? 5 : 7));
			if ((i % 8) == 7)
				read_recent();
		end
		write_reg(REG_STRIDE, CFG_DATA_W'(STRIDE_RESET));
	endtask

	// tiny, zero and oversized cell counts, wide strides, lowered modulus
	task automatic test_register_extremes();
		feed_gap_en    = 1'b1;
		drain_stall_en = 1'b1;
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(2));
		write_reg(REG_STRIDE, CFG_DATA_W'(1));
		run_mix(12, 30);
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(1));
		run_mix(10, 30);
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(0));
		write_reg(REG_STRIDE, CFG_DATA_W'(4095));
		run_mix(12, 30);
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(8191));
		run_mix(10, 30);
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(100));
		run_mix(12, 30);
		write_reg(REG_STRIDE, CFG_DATA_W'(1000));
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(4096));
		run_mix(8, 0);
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(7));
		run_mix(12, 30);
		write_reg(REG_STRIDE, CFG_DATA_W'(STRIDE_RESET));
		write_reg(REG_CELLS_IN_USE, CFG_DATA_W'(CELLS_USE_RESET));
	endtask

	// reads of bins past the last one return zero
	task automatic test_read_out_of_range();
		feed_gap_en    = 1'b1;
		drain_stall_en = 1'b1;
		for (int b = BINS; b < 16; b++) begin
			send_item(read_of(int'($urandom_range(0, 4095)), b));
			send_item(read_of(0, b));
		end
	endtask

	// reads back to back against a stalling result side
	task automatic test_result_backpressure();
		feed_gap_en    = 1'b0;
		drain_stall_en = 1'b1;
		for (int i = 0; i < 40; i++) begin
			if ((i % 4) == 3)
				send_item(add_of(int'($urandom_range(0, 255))));
			else
				read_recent();
		end
	endtask

	// random items, random gaps, occasional register changes
	task automatic test_random_traffic();
		int pick;
		feed_gap_en    = 1'b1;
		drain_stall_en = 1'b1;
		for (int i = 0; i < 330; i++) begin
			if ((i % 110) == 109) begin
				write_reg(REG_STRIDE, CFG_DATA_W'($urandom_range(0, 4095)));
				write_reg(REG_CELLS_IN_USE, CFG_DATA_W'($urandom_range(2, 4096)));
			end
			pick = int'($urandom_range(0, 99));
			if (pick < 20)
				read_recent();
			else if (pick < 25)
				send_item(read_of(int'($urandom_range(0, 4095)),
					int'($urandom_range(0, 15))));
			else
				send_item(add_of(int'($urandom_range(0, 255))));
		end
	endtask

	// drain, summarize, report
	task automatic finish_run();
		push <= 1'b0;
		while (read_expect.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (results_seen != reads_sent) begin
			$error("results: expected %0d, got %0d", reads_sent, results_seen);
			mismatches++;
		end
		$display("sent %0d adds and %0d reads around %0d register writes",
			adds_sent, reads_sent, reg_writes);
		$display("every weight, same-entry bursts, odd cell counts, bad bins, stalled pops");
		if (mismatches == 0)
			$display("tb_strided_cell_bin_histogram_core: clean");
		else
			$display("tb_strided_cell_bin_histogram_core: errors");
		$finish;
	endtask

	initial begin
		init_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_bin_edges();
		test_same_entry();
		test_register_extremes();
		test_read_out_of_range();
		test_result_backpressure();
		test_random_traffic();
		finish_run();
	end
endmodule

// ===== strided_cell_bin_histogram_core.f =====
sv/scbh_pkg.sv
sv/scbh_fifo.sv
sv/scbh_front.sv
sv/scbh_back.sv
sv/strided_cell_bin_histogram_core.sv
test/tb_strided_cell_bin_histogram_core.sv
